// File: hdl/shash_pkg.sv
// Package for the sponge hash: queue entry type, state encoding, round constants
// and lane rotation amounts. No dependencies.
package shash_pkg;

   typedef logic [63:0] lane_type;
   typedef lane_type [24:0] state_type;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        message_end;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PERMUTE,
      ST_PAD,
      ST_EMIT
   } core_state_type;

   localparam int RC_COUNT = 80;

   function automatic lane_type round_const(input logic [6:0] rnd);
      lane_type c;
      case (rnd)
         7'd0: c = 64'h6A09E667F3BCC908;  7'd1: c = 64'hBB67AE8584CAA73B;
         7'd2: c = 64'h3C6EF372FE94F82B;  7'd3: c = 64'h7311C2812425CFA0;
         7'd4: c = 64'hA54FF53A5F1D36F1;  7'd5: c = 64'hD413CCCFE7799211;
         7'd6: c = 64'h298B075B4B6A5240;  7'd7: c = 64'h510E527FADE682D1;
         7'd8: c = 64'h76CF5D0B09954E76;  7'd9: c = 64'h9B05688C2B3E6C1F;
         7'd10: c = 64'hBDDD422D07E9240A; 7'd11: c = 64'hDF7BD629E9DB362F;
         7'd12: c = 64'h1F83D9ABFB41BD6B; 7'd13: c = 64'h3E1DB337DB365B1A;
         7'd14: c = 64'h5BE0CD19137E2179; 7'd15: c = 64'h78DDE6E5FD29F057;
         7'd16: c = 64'h9523AE4547A14CCC; 7'd17: c = 64'hB0BF165515A9B348;
         7'd18: c = 64'hCBBB9D5DC1059ED8; 7'd19: c = 64'hE6238502484B9F40;
         7'd20: c = 64'h195957C48BFD9862; 7'd21: c = 64'h32370B908E5FF5B1;
         7'd22: c = 64'h4A9FEA74BE3A6DE3; 7'd23: c = 64'h629A292A367CD507;
         7'd24: c = 64'h7A2B748DA963BC20; 7'd25: c = 64'h9159015A3070DD17;
         7'd26: c = 64'hA827999FCEF32422; 7'd27: c = 64'hBE9BA858B43C0323;
         7'd28: c = 64'hD4B9436CE8E86C6C; 7'd29: c = 64'hEA843464F08B39BC;
         7'd30: c = 64'h152FECD8F70E5939; 7'd31: c = 64'h2A17093DC1965F6E;
         7'd32: c = 64'h3EB83056B4E27892; 7'd33: c = 64'h53160EB696D4A481;
         7'd34: c = 64'h67332667FFC00B31; 7'd35: c = 64'h7B11D2898498F55F;
         7'd36: c = 64'h8EB44A8768581511; 7'd37: c = 64'hA21CA4FF5BCD05A3;
         7'd38: c = 64'hB54CDA58FBBEE883; 7'd39: c = 64'hC846C71C3408C03C;
         7'd40: c = 64'hDB0C2E0D64F98FA7; 7'd41: c = 64'hED9EBA16132A9CEC;
         7'd42: c = 64'h12318007C2AFED2B; 7'd43: c = 64'h2434A74B50F36125;
         7'd44: c = 64'h360AD118567CD83F; 7'd45: c = 64'h47B5481DBEFA4FA4;
         7'd46: c = 64'h593547836C716EE1; 7'd47: c = 64'h6A8BFBEAB875FD80;
         7'd48: c = 64'h7BBA845A0FD24815; 7'd49: c = 64'h8CC1F315B3D6F707;
         7'd50: c = 64'h9DA34E67711BE573; 7'd51: c = 64'hAE5F9156E7B6D99B;
         7'd52: c = 64'hBEF7AC53D3B66C5E; 7'd53: c = 64'hCF6C85D39D1A1E15;
         7'd54: c = 64'hDFBEFAE353C4785E; 7'd55: c = 64'hEFEFDFAF1D57A4D5;
         7'd56: c = 64'h0FF01FB0DD682588; 7'd57: c = 64'h1FC0FB1B5C05DE20;
         7'd58: c = 64'h2F73477D6A4563CA; 7'd59: c = 64'h3F07B357F6837AD6;
         7'd60: c = 64'h4E7EE6C768047F3C; 7'd61: c = 64'h5DD983D657ED756A;
         7'd62: c = 64'h6D1826CAFD82E1ED; 7'd63: c = 64'h7C3B666FB66CB634;
         7'd64: c = 64'h8B43D4570A51B936; 7'd65: c = 64'h9A31FD1B80A706CA;
         7'd66: c = 64'hA906689B97F54427; 7'd67: c = 64'hB7C19A3226FC42F3;
         7'd68: c = 64'hC66410EB69F159EA; 7'd69: c = 64'hD4EE47B6F881C075;
         7'd70: c = 64'hE360B596DC380C3F; 7'd71: c = 64'hF1BBCDCBFA53E0AF;
         7'd72: c = 64'h0E2DB86CFC11CF76; 7'd73: c = 64'h1C456002CE13E9F8;
         7'd74: c = 64'h2A475C8A8F429998; 7'd75: c = 64'h383410C8174D10FF;
         7'd76: c = 64'h460BDC99BC19F287; 7'd77: c = 64'h53CF1D166972D444;
         7'd78: c = 64'h617E2CAA2B536690; 7'd79: c = 64'h6F19633143A0AF0E;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Rotation amount for the lane at flat index x + 5*y.
   function automatic logic [5:0] rot_amt(input int idx);
      logic [5:0] r;
      case (idx)
         0: r = 6'd0;   5: r = 6'd1;   10: r = 6'd62; 15: r = 6'd28; 20: r = 6'd27;
         1: r = 6'd36;  6: r = 6'd44;  11: r = 6'd6;  16: r = 6'd55; 21: r = 6'd20;
         2: r = 6'd3;   7: r = 6'd10;  12: r = 6'd43; 17: r = 6'd25; 22: r = 6'd39;
         3: r = 6'd41;  8: r = 6'd45;  13: r = 6'd15; 18: r = 6'd21; 23: r = 6'd8;
         4: r = 6'd18;  9: r = 6'd2;   14: r = 6'd61; 19: r = 6'd56; 24: r = 6'd14;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic lane_type rotl(input lane_type v, input logic [5:0] n);
      lane_type dbl;
      dbl = '0;
      if (n != 6'd0) begin
         dbl = (v << n) | (v >> (7'd64 - {1'b0, n}));
      end else begin
         dbl = v;
      end
      return dbl;
   endfunction

endpackage

// File: hdl/shash_queue.sv
// Two-entry queue between the input side and the sponge core.
// Depends on shash_pkg for the entry type.
module shash_queue
   import shash_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_take,
   output entry_type out_entry
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_take && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// File: hdl/shash_core.sv
// Sponge core: absorbs queued items one byte slot at a time per word, runs
// one round per cycle and emits eight digest words. Depends on shash_pkg.
module shash_core
   import shash_pkg::*;
#(
   parameter int ROUNDS = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_take,
   input  entry_type   q_entry,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   core_state_type state_ff, state_in;
   state_type      lanes_ff, lanes_in;
   logic [5:0]     pos_ff, pos_in;
   logic [6:0]     rnd_ff, rnd_in;
   logic [3:0]     k_ff, k_in;        // byte within the current word
   logic           last_ff, last_in;  // this permutation is the last: emit the digest after it
   logic [2:0]     idx_ff, idx_in;
   state_type      round_out;
   logic [3:0]     cnt;
   logic [4:0]     lane_sel;
   logic [5:0]     sh;

   // One full round, combinational on the state register.
   always_comb begin
      lane_type col [5];
      lane_type dif [5];
      lane_type tmp [25];
      for (int x = 0; x < 5; x++) begin
         col[x] = lanes_ff[x] ^ lanes_ff[x+5] ^ lanes_ff[x+10] ^ lanes_ff[x+15]
                  ^ lanes_ff[x+20];
      end
      for (int x = 0; x < 5; x++) begin
         dif[x] = col[(x+4)%5] ^ {col[(x+1)%5][62:0], col[(x+1)%5][63]};
      end
      for (int x = 0; x < 5; x++) begin
         for (int y = 0; y < 5; y++) begin
            tmp[y + 5*((2*x + 3*y) % 5)] = rotl(lanes_ff[x+5*y] ^ dif[x], rot_amt(x+5*y));
         end
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            round_out[x+5*y] = tmp[x+5*y] ^ (~tmp[(x+1)%5+5*y] & tmp[(x+2)%5+5*y]);
         end
      end
      round_out[0] = round_out[0] ^ round_const(rnd_ff);
   end

   assign cnt      = (q_entry.byte_count > 4'd8) ? 4'd8 : q_entry.byte_count;
   assign lane_sel = {2'b00, pos_ff[5:3]};
   assign sh       = {pos_ff[2:0], 3'b000};

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = lanes_ff[{2'b00, idx_ff}];
   assign rsp_word_index  = idx_ff;
   assign rsp_digest_last = (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      lanes_in = lanes_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      q_take   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            k_in = 4'd0;
            if (q_valid) begin
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            // One byte per cycle; a full block goes to the permutation at once.
            if (k_ff < cnt) begin
               lanes_in[lane_sel] = lanes_ff[lane_sel]
                  ^ ({56'd0, q_entry.data_word[{k_ff[2:0], 3'b000} +: 8]} << sh);
               pos_in = pos_ff + 6'd1;
               k_in   = k_ff + 4'd1;
               if (pos_ff == 6'd63) begin
                  last_in  = 1'b0;
                  rnd_in   = 7'd0;
                  state_in = ST_PERMUTE;
               end
            end else begin
               q_take = 1'b1;
               if (q_entry.message_end) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            lanes_in[lane_sel] = lanes_ff[lane_sel] ^ ({56'd0, 8'h01} << sh);
            lanes_in[7] = lanes_in[7] ^ {8'h80, 56'd0};
            last_in  = 1'b1;
            rnd_in   = 7'd0;
            state_in = ST_PERMUTE;
         end
         ST_PERMUTE: begin
            lanes_in = round_out;
            rnd_in   = rnd_ff + 7'd1;
            if ((rnd_ff == 7'(ROUNDS - 1)) || (rnd_ff == 7'(RC_COUNT - 1))) begin
               rnd_in = 7'd0;
               if (last_ff) begin
                  idx_in   = 3'd0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_ABSORB;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  lanes_in = '0;
                  pos_in   = 6'd0;
                  last_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lanes_ff <= '0;
         pos_ff   <= 6'd0;
         rnd_ff   <= 7'd0;
         k_ff     <= 4'd0;
         last_ff  <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         lanes_ff <= lanes_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: hdl/sponge_hash_512_80_rounds.sv
// Channel   Valid      Stall      Payload
// req       req_valid  req_stall  req_data_word, req_byte_count, req_message_end
// rsp       rsp_valid  rsp_stall  rsp_digest_word, rsp_word_index, rsp_digest_last
// Each item passes through an idle state, absorbs one valid byte a cycle and is then taken
// from the queue; a full 64-byte block adds a permutation of ROUNDS rounds on the single
// round unit.
// Last item adds padding, ROUNDS rounds and eight digest items, one a cycle unless stalled.
// Synchronous active-high reset clears the state; a two-entry queue lets input
// items be taken while the core is busy or the output is stalled.
// Top level of the sponge hash; instantiates shash_queue and shash_core, uses shash_pkg.
module sponge_hash_512_80_rounds
   import shash_pkg::*;
#(
   parameter int ROUNDS = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   entry_type in_entry, q_entry;
   logic      q_valid, q_take;

   assign in_entry = '{data_word: req_data_word, byte_count: req_byte_count,
                       message_end: req_message_end};

   shash_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_entry  (in_entry),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_entry (q_entry)
   );

   shash_core #(.ROUNDS(ROUNDS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_take          (q_take),
      .q_entry         (q_entry),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last)
   );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for sponge_hash_512_80_rounds: drives message items,
// predicts the eight digest words per message and checks them field by field.
// Depends on shash_pkg for the round constants.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import shash_pkg::*;

   localparam int HASH_ROUNDS = 80;
   localparam int BLOCK_BYTES = 64;
   localparam int IDLE_LIMIT  = 20000;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
      logic        known;
      logic [63:0] digest0;
   } stim_row_type;

   typedef struct {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_message_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_last;

   sponge_hash_512_80_rounds u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Predictor state
   logic [63:0] hash_lanes [25];
   int          hash_pos;
   digest_type  pending_digests [$];
   logic [63:0] known_digest0 [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          stim_done = 1'b0;

   // Rotation amounts, flat index x + 5*y
   localparam int ROT_TABLE [25] = '{0, 36, 3, 41, 18, 1, 44, 10, 45, 2,
                                     62, 6, 43, 15, 61, 28, 55, 25, 21, 56,
                                     27, 20, 39, 8, 14};

   function automatic logic [63:0] rotate_lane(logic [63:0] v, int n);
      if (n == 0) return v;
      return (v << n) | (v >> (64 - n));
   endfunction

   task automatic permute_lanes();
      logic [63:0] col [5];
      logic [63:0] dif [5];
      logic [63:0] tmp [25];
      logic [63:0] row [5];
      for (int r = 0; r < HASH_ROUNDS; r++) begin
         for (int x = 0; x < 5; x++)
            col[x] = hash_lanes[x] ^ hash_lanes[x+5] ^ hash_lanes[x+10]
                     ^ hash_lanes[x+15] ^ hash_lanes[x+20];
         for (int x = 0; x < 5; x++)
            dif[x] = col[(x+4)%5] ^ rotate_lane(col[(x+1)%5], 1);
         // tmp is indexed [x][y] as x + 5*y, with the lane moving to (y, 2x+3y)
         for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
               tmp[y + 5*((2*x + 3*y) % 5)] =
                  rotate_lane(hash_lanes[x + 5*y] ^ dif[x], ROT_TABLE[x + 5*y]);
         for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) row[x] = tmp[x + 5*y];
            for (int x = 0; x < 5; x++)
               hash_lanes[x + 5*y] = row[x] ^ (~row[(x+1)%5] & row[(x+2)%5]);
         end
         hash_lanes[0] ^= round_const(r[6:0]);
      end
   endtask

   task automatic absorb_byte(int pos, logic [7:0] b);
      hash_lanes[(pos % 64) / 8][8*(pos % 8) +: 8] ^= b;
   endtask

   task automatic predict_hash(logic [63:0] word, logic [3:0] count, logic last);
      int n;
      digest_type d;
      n = (count > 8) ? 8 : int'(count);
      for (int k = 0; k < n; k++) begin
         absorb_byte(hash_pos, word[8*k +: 8]);
         hash_pos++;
         if (hash_pos >= BLOCK_BYTES) begin
            permute_lanes();
            hash_pos = 0;
         end
      end
      if (last) begin
         absorb_byte(hash_pos, 8'h01);
         absorb_byte(BLOCK_BYTES - 1, 8'h80);
         permute_lanes();
         for (int k = 0; k < 8; k++) begin
            d.word  = hash_lanes[k];
            d.index = k[2:0];
            d.last  = (k == 7);
            pending_digests = {pending_digests, d};
         end
         foreach (hash_lanes[i]) hash_lanes[i] = '0;
         hash_pos = 0;
      end
   endtask

   task automatic send_item(logic [63:0] word, logic [3:0] count, logic last);
      // Random gap before the item, mostly short
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= word;
      req_byte_count  <= count;
      req_message_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_hash(word, count, last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digests.size() != 0) @(posedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      digest_type d;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digests.size() == 0) begin
            $error("unexpected digest item %h", rsp_digest_word);
            error_count++;
         end else begin
            d = pending_digests.pop_front();
            if (d.index == 3'd0 && known_digest0.size() != 0) begin
               if (known_digest0[0] !== rsp_digest_word) begin
                  $error("digest_word (typed) expected %h actual %h",
                         known_digest0[0], rsp_digest_word);
                  error_count++;
               end
               void'(known_digest0.pop_front());
            end
            if (d.word !== rsp_digest_word) begin
               $error("digest_word expected %h actual %h", d.word, rsp_digest_word);
               error_count++;
            end
            if (d.index !== rsp_word_index) begin
               $error("word_index expected %0d actual %0d", d.index, rsp_word_index);
               error_count++;
            end
            if (d.last !== rsp_digest_last) begin
               $error("digest_last expected %0d actual %0d", d.last, rsp_digest_last);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls, with stretches of none
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stim_done || r < 40) rsp_stall <= 1'b0;
      else if (r < 43) rsp_stall <= 1'b1;
      else if (r < 70) rsp_stall <= ($urandom_range(0, 2) == 0);
      else rsp_stall <= rsp_stall;
   end

   // Watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   stim_row_type directed [] = '{
      // Empty message: the digest of a lone padding block is not typed in
      '{64'h0, 4'd0, 1'b1, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0},
      '{64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b0, 1'b0, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 4'd3, 1'b1, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FF00, 4'd1, 1'b1, 1'b0, 64'h0},
      '{64'h5A5A_5A5A_5A5A_5A5A, 4'd7, 1'b1, 1'b0, 64'h0},
      '{64'h0, 4'd0, 1'b0, 1'b0, 64'h0},
      '{64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b1, 1'b0, 64'h0}
   };

   initial begin
      int n_words;
      int items;
      logic [63:0] w;
      foreach (hash_lanes[i]) hash_lanes[i] = '0;
      hash_pos = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].known) known_digest0 = {known_digest0, directed[i].digest0};
         send_item(directed[i].word, directed[i].count, directed[i].last);
      end
      // Exactly 64 bytes, then 63 bytes: full padding block and merged pad byte
      for (int k = 0; k < 8; k++) send_item({$urandom, $urandom}, 4'd8, k == 7);
      for (int k = 0; k < 8; k++) send_item({$urandom, $urandom}, (k == 7) ? 4'd7 : 4'd8,
                                            k == 7);
      wait_drained();

      items = 0;
      while (items < 275) begin
         // Mostly messages of up to twelve words, some of 17 to 40; some inner words are short
         n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 12);
         for (int k = 0; k < n_words; k++) begin
            w = {$urandom, $urandom};
            if (k == n_words - 1)
               send_item(w, 4'($urandom_range(0, 15)), 1'b1);
            else if ($urandom_range(0, 9) == 0)
               send_item(w, 4'($urandom_range(0, 15)), 1'b0);
            else
               send_item(w, 4'd8, 1'b0);
            items++;
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
      stim_done = 1'b1;
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_digests.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
